/* rtl/core/quadratic_root_solver_assert.svh */
// Assertion helpers for the quadratic root solver.
// Expects clk and arst_n in the scope of use.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// same-cycle implication
`define QRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/qrs_pkg.sv */
`timescale 1ns / 1ps
package qrs_pkg;

	localparam int DEF_WORD_BITS = 32;
	localparam int DEF_FRAC_BITS = 16;
	localparam int QUEUE_DEPTH   = 4;

	typedef enum logic [2:0] {
		KIND_TWO_REAL = 3'd0,
		KIND_COMPLEX  = 3'd1,
		KIND_DOUBLE   = 3'd2,
		KIND_LINEAR   = 3'd3,
		KIND_CONST    = 3'd4,
		KIND_IDENTITY = 3'd5
	} kind_t;

endpackage

/* rtl/core/qrs_coef_if.sv */
`timescale 1ns / 1ps
interface qrs_coef_if #(parameter int WORD_BITS = qrs_pkg::DEF_WORD_BITS) ();
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] coef_a;
	logic signed [WORD_BITS-1:0] coef_b;
	logic signed [WORD_BITS-1:0] coef_c;

	modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
	modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

/* rtl/core/qrs_root_if.sv */
`timescale 1ns / 1ps
interface qrs_root_if #(parameter int WORD_BITS = qrs_pkg::DEF_WORD_BITS) ();
	logic                        valid;
	logic                        ready;
	qrs_pkg::kind_t              root_kind;
	logic signed [WORD_BITS-1:0] root_first;
	logic signed [WORD_BITS-1:0] root_second;
	logic                        saturated;

	modport source (output valid, output root_kind, output root_first, output root_second,
		output saturated, input ready);
	modport sink   (input valid, input root_kind, input root_first, input root_second,
		input saturated, output ready);
endinterface

/* rtl/core/qrs_front.sv */
`timescale 1ns / 1ps
// Front: magnitudes and products, then discriminant and classification.
module qrs_front #(
	parameter int WORD_BITS = qrs_pkg::DEF_WORD_BITS,
	parameter int DEPTH     = qrs_pkg::QUEUE_DEPTH,
	localparam int W  = WORD_BITS,
	localparam int DW = 2 * WORD_BITS + 1,
	localparam int EW = 3 + DW + 3 * WORD_BITS,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	qrs_coef_if.sink        coef,
	input  logic [CW-1:0]   queue_cnt,
	output logic            push,
	output logic [EW-1:0]   push_data
);
	logic              v_s1, v_s2;
	logic signed [W-1:0] a_s1, b_s1, c_s1, a_s2, b_s2, c_s2;
	logic [2*W-1:0]    ac_s1, bb_s1;
	logic [DW-1:0]     dmag_s2;
	qrs_pkg::kind_t    kind_s2;

	logic [W-1:0]      am, bm, cm;
	logic [CW+1:0]     occ;
	logic [2*W+1:0]    b2, ac4, sum, dif1, dif2, dmag;
	logic              opp, ge, dneg;
	qrs_pkg::kind_t    kind;
	logic              take;

	// credit: items in flight here plus queued never exceed the queue depth
	assign occ        = (CW+2)'(queue_cnt) + (CW+2)'(v_s1) + (CW+2)'(v_s2);
	assign coef.ready = occ < (CW+2)'(DEPTH);
	assign take       = coef.valid & coef.ready;

	assign am = coef.coef_a[W-1] ? W'(-coef.coef_a) : W'(coef.coef_a);
	assign bm = coef.coef_b[W-1] ? W'(-coef.coef_b) : W'(coef.coef_b);
	assign cm = coef.coef_c[W-1] ? W'(-coef.coef_c) : W'(coef.coef_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s1  <= coef.coef_a;
		b_s1  <= coef.coef_b;
		c_s1  <= coef.coef_c;
		ac_s1 <= am * cm;
		bb_s1 <= bm * bm;
	end

	assign b2   = {2'b00, bb_s1};
	assign ac4  = {ac_s1, 2'b00};
	assign sum  = b2 + ac4;
	assign dif1 = b2 - ac4;
	assign dif2 = ac4 - b2;
	assign ge   = b2 >= ac4;
	assign opp  = (c_s1 != '0) && (a_s1[W-1] != c_s1[W-1]);
	assign dmag = opp ? sum : (ge ? dif1 : dif2);
	assign dneg = !opp && !ge;

	always_comb begin
		if (a_s1 != '0) begin
			if (dneg)
				kind = qrs_pkg::KIND_COMPLEX;
			else if (dmag != '0)
				kind = qrs_pkg::KIND_TWO_REAL;
			else
				kind = qrs_pkg::KIND_DOUBLE;
		end else if (b_s1 != '0) begin
			kind = qrs_pkg::KIND_LINEAR;
		end else if (c_s1 != '0) begin
			kind = qrs_pkg::KIND_CONST;
		end else begin
			kind = qrs_pkg::KIND_IDENTITY;
		end
	end

	always_ff @(posedge clk) begin
		a_s2    <= a_s1;
		b_s2    <= b_s1;
		c_s2    <= c_s1;
		dmag_s2 <= dmag[DW-1:0];
		kind_s2 <= kind;
	end

	assign push      = v_s2;
	assign push_data = {kind_s2, dmag_s2, a_s2, b_s2, c_s2};
endmodule

/* rtl/core/qrs_fifo.sv */
`timescale 1ns / 1ps
// Small show-ahead queue between front and back.
module qrs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = qrs_pkg::QUEUE_DEPTH,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data,
	output logic [CW-1:0]    count
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	assign not_empty = cnt_q != '0;
	assign pop_data  = mem_q[rd_q];
	assign count     = cnt_q;
endmodule

/* rtl/core/qrs_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined floor square root, one root bit per stage.
module qrs_sqrt #(
	parameter int SW     = 33,
	parameter int SIDE_W = 1,
	localparam int DB = 2 * SW,
	localparam int RW = SW + 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DB-1:0]     radicand,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [SW-1:0]     root,
	output logic [SIDE_W-1:0] out_side
);
	logic              v_q    [SW];
	logic [RW-1:0]     rem_q  [SW];
	logic [SW-1:0]     root_q [SW];
	logic [DB-1:0]     d_q    [SW];
	logic [SIDE_W-1:0] side_q [SW];

	for (genvar i = 0; i < SW; i++) begin : g_stage
		logic              v_c;
		logic [RW-1:0]     rem_c, rem_sh, trial;
		logic [SW-1:0]     root_c;
		logic [DB-1:0]     d_c;
		logic [SIDE_W-1:0] side_c;
		logic              ge;

		if (i == 0) begin : g_first
			assign v_c    = in_valid;
			assign rem_c  = '0;
			assign root_c = '0;
			assign d_c    = radicand;
			assign side_c = in_side;
		end else begin : g_next
			assign v_c    = v_q[i-1];
			assign rem_c  = rem_q[i-1];
			assign root_c = root_q[i-1];
			assign d_c    = d_q[i-1];
			assign side_c = side_q[i-1];
		end

		assign rem_sh = {rem_c[RW-3:0], d_c[DB-1 -: 2]};
		assign trial  = {root_c, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_q[i] <= 1'b0;
			else if (en)
				v_q[i] <= v_c;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i]  <= ge ? rem_sh - trial : rem_sh;
				root_q[i] <= {root_c[SW-2:0], ge};
				d_q[i]    <= {d_c[DB-3:0], 2'b00};
				side_q[i] <= side_c;
			end
		end
	end

	assign out_valid = v_q[SW-1];
	assign root      = root_q[SW-1];
	assign out_side  = side_q[SW-1];
endmodule

/* rtl/core/qrs_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
module qrs_div #(
	parameter int QW     = 49,
	parameter int DNW    = 33,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [QW-1:0]     dividend,
	input  logic [DNW-1:0]    divisor,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [QW-1:0]     quotient,
	output logic [SIDE_W-1:0] out_side
);
	logic              v_q    [QW];
	logic [DNW-1:0]    rem_q  [QW];
	logic [QW-1:0]     nq_q   [QW];
	logic [DNW-1:0]    dm_q   [QW];
	logic [SIDE_W-1:0] side_q [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic              v_c;
		logic [DNW-1:0]    rem_c, rem_sh, dm_c;
		logic [QW-1:0]     nq_c;
		logic [SIDE_W-1:0] side_c;
		logic              ge;

		if (i == 0) begin : g_first
			assign v_c    = in_valid;
			assign rem_c  = '0;
			assign nq_c   = dividend;
			assign dm_c   = divisor;
			assign side_c = in_side;
		end else begin : g_next
			assign v_c    = v_q[i-1];
			assign rem_c  = rem_q[i-1];
			assign nq_c   = nq_q[i-1];
			assign dm_c   = dm_q[i-1];
			assign side_c = side_q[i-1];
		end

		// remainder stays below divisor, so its top bit is always clear
		assign rem_sh = {rem_c[DNW-2:0], nq_c[QW-1]};
		assign ge     = rem_sh >= dm_c;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_q[i] <= 1'b0;
			else if (en)
				v_q[i] <= v_c;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i]  <= ge ? rem_sh - dm_c : rem_sh;
				nq_q[i]   <= {nq_c[QW-2:0], ge};
				dm_q[i]   <= dm_c;
				side_q[i] <= side_c;
			end
		end
	end

	assign out_valid = v_q[QW-1];
	assign quotient  = nq_q[QW-1];
	assign out_side  = side_q[QW-1];
endmodule

/* rtl/core/qrs_back.sv */
`timescale 1ns / 1ps
// Back: square root, operand setup, two dividers, saturation, output register.
module qrs_back #(
	parameter int WORD_BITS = qrs_pkg::DEF_WORD_BITS,
	parameter int FRAC_BITS = qrs_pkg::DEF_FRAC_BITS,
	localparam int W   = WORD_BITS,
	localparam int F   = FRAC_BITS,
	localparam int DW  = 2 * W + 1,
	localparam int EW  = 3 + DW + 3 * W,
	localparam int SW  = W + 1,
	localparam int NW  = W + 2,
	localparam int DNW = W + 1,
	localparam int QW  = W + 1 + F,
	localparam int S1W = 3 + 3 * W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          entry_valid,
	input  logic [EW-1:0] entry,
	output logic          pop,
	qrs_root_if.source    root
);
	logic                en;
	logic                out_valid_q;

	qrs_pkg::kind_t      e_kind;
	logic [DW-1:0]       e_dmag;
	logic signed [W-1:0] e_a, e_b, e_c;

	logic                sq_valid;
	logic [SW-1:0]       sq_root;
	logic [S1W-1:0]      sq_side;
	qrs_pkg::kind_t      sq_kind;
	logic signed [W-1:0] sq_a, sq_b, sq_c;

	logic signed [NW-1:0] a_x, nb, s_x, n1, n2, d1, d2;
	logic                 use1, use2;

	logic                 v_s1, v_s2;
	qrs_pkg::kind_t       kind_s1, kind_s2;
	logic signed [NW-1:0] n1_s1, n2_s1, d1_s1, d2_s1;
	logic                 use1_s1, use2_s1, use1_s2, use2_s2, neg1_s2, neg2_s2;
	logic [QW-1:0]        x1_s2, x2_s2;
	logic [DNW-1:0]       y1_s2, y2_s2;
	logic signed [NW-1:0] n1m, n2m, d1m, d2m;

	logic                 q1_valid, q2_valid;
	logic [QW-1:0]        q1, q2;
	logic [4:0]           q1_side;
	logic [1:0]           q2_side;
	qrs_pkg::kind_t       f_kind;
	logic                 f_neg1, f_use1, f_neg2, f_use2;
	logic [W-1:0]         r1, r2;
	logic                 sat1, sat2;

	qrs_pkg::kind_t       kind_q;
	logic [W-1:0]         first_q, second_q;
	logic                 sat_q;

	assign en  = !out_valid_q || root.ready;
	assign pop = en && entry_valid;

	assign {e_kind, e_dmag, e_a, e_b, e_c} = entry;

	qrs_sqrt #(.SW(SW), .SIDE_W(S1W)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (entry_valid),
		.radicand  ((2*SW)'(e_dmag)),
		.in_side   ({e_kind, e_a, e_b, e_c}),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	assign {sq_kind, sq_a, sq_b, sq_c} = sq_side;
	assign a_x = NW'(sq_a);
	assign nb  = -NW'(sq_b);
	assign s_x = $signed({1'b0, sq_root});

	// numerators and denominators per kind; an unused divider sees 0 / 1
	always_comb begin
		n1 = '0;
		n2 = '0;
		d1 = NW'(1);
		d2 = NW'(1);
		use1 = 1'b0;
		use2 = 1'b0;
		unique case (sq_kind)
			qrs_pkg::KIND_TWO_REAL: begin
				n1 = nb + s_x;
				n2 = nb - s_x;
				d1 = a_x <<< 1;
				d2 = a_x <<< 1;
				use1 = 1'b1;
				use2 = 1'b1;
			end
			qrs_pkg::KIND_COMPLEX: begin
				n1 = nb;
				n2 = s_x;
				d1 = a_x <<< 1;
				d2 = sq_a[W-1] ? -(a_x <<< 1) : (a_x <<< 1);
				use1 = 1'b1;
				use2 = 1'b1;
			end
			qrs_pkg::KIND_DOUBLE: begin
				n1 = nb;
				d1 = a_x <<< 1;
				use1 = 1'b1;
			end
			qrs_pkg::KIND_LINEAR: begin
				n1 = -NW'(sq_c);
				d1 = NW'(sq_b);
				use1 = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= sq_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= sq_kind;
			n1_s1   <= n1;
			n2_s1   <= n2;
			d1_s1   <= d1;
			d2_s1   <= d2;
			use1_s1 <= use1;
			use2_s1 <= use2;
		end
	end

	assign n1m = n1_s1[NW-1] ? -n1_s1 : n1_s1;
	assign n2m = n2_s1[NW-1] ? -n2_s1 : n2_s1;
	assign d1m = d1_s1[NW-1] ? -d1_s1 : d1_s1;
	assign d2m = d2_s1[NW-1] ? -d2_s1 : d2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			use1_s2 <= use1_s1;
			use2_s2 <= use2_s1;
			neg1_s2 <= n1_s1[NW-1] ^ d1_s1[NW-1];
			neg2_s2 <= n2_s1[NW-1] ^ d2_s1[NW-1];
			x1_s2   <= {n1m[NW-2:0], {F{1'b0}}};
			x2_s2   <= {n2m[NW-2:0], {F{1'b0}}};
			y1_s2   <= d1m[NW-2:0];
			y2_s2   <= d2m[NW-2:0];
		end
	end

	qrs_div #(.QW(QW), .DNW(DNW), .SIDE_W(5)) u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.dividend  (x1_s2),
		.divisor   (y1_s2),
		.in_side   ({kind_s2, neg1_s2, use1_s2}),
		.out_valid (q1_valid),
		.quotient  (q1),
		.out_side  (q1_side)
	);

	// runs in lockstep with the first divider
	qrs_div #(.QW(QW), .DNW(DNW), .SIDE_W(2)) u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.dividend  (x2_s2),
		.divisor   (y2_s2),
		.in_side   ({neg2_s2, use2_s2}),
		.out_valid (q2_valid),
		.quotient  (q2),
		.out_side  (q2_side)
	);

	assign {f_kind, f_neg1, f_use1} = q1_side;
	assign {f_neg2, f_use2}         = q2_side;

	// clamp to the signed word range, then apply the sign
	always_comb begin
		logic [QW-1:0] lim1, lim2;
		lim1 = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}} + QW'(f_neg1);
		lim2 = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}} + QW'(f_neg2);
		sat1 = f_use1 && (q1 > lim1);
		sat2 = f_use2 && (q2 > lim2);
		if (!f_use1)
			r1 = '0;
		else if (sat1)
			r1 = f_neg1 ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		else
			r1 = f_neg1 ? -q1[W-1:0] : q1[W-1:0];
		if (!f_use2)
			r2 = '0;
		else if (sat2)
			r2 = f_neg2 ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		else
			r2 = f_neg2 ? -q2[W-1:0] : q2[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= q1_valid & q2_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_q   <= f_kind;
			first_q  <= r1;
			second_q <= r2;
			sat_q    <= sat1 | sat2;
		end
	end

	assign root.valid       = out_valid_q;
	assign root.root_kind   = kind_q;
	assign root.root_first  = $signed(first_q);
	assign root.root_second = $signed(second_q);
	assign root.saturated   = sat_q;
endmodule

/* rtl/core/quadratic_root_solver.sv */
`timescale 1ns / 1ps
// channel | dir | word contents                                          | handshake
// coef    | in  | coef_a, coef_b, coef_c (signed Q format)               | valid/ready
// root    | out | root_kind, root_first, root_second, saturated          | valid/ready
//
// One word in and one word out per cycle, sustained while root.ready stays high.
// Path from input to output handshake: two front stages, the queue, WORD_BITS+1
// square root stages, two setup stages, WORD_BITS+FRAC_BITS+1 divider stages and
// the output register.
// arst_n clears all valid bits and queue pointers; no clearing pass.
// An output stall freezes the back pipeline; the front keeps taking words
// until the front stages plus the queue hold QUEUE_DEPTH words.
module quadratic_root_solver #(
	parameter int WORD_BITS = qrs_pkg::DEF_WORD_BITS,
	parameter int FRAC_BITS = qrs_pkg::DEF_FRAC_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	qrs_coef_if.sink   coef,
	qrs_root_if.source root
);
	localparam int DEPTH = qrs_pkg::QUEUE_DEPTH;
	localparam int DW    = 2 * WORD_BITS + 1;
	localparam int EW    = 3 + DW + 3 * WORD_BITS;
	localparam int CW    = $clog2(DEPTH + 1);

	logic          push, pop, q_not_empty;
	logic [EW-1:0] push_data, pop_data;
	logic [CW-1:0] q_cnt;

	// front: |a|,|b|,|c| and products, then discriminant sign/magnitude and kind
	qrs_front #(.WORD_BITS(WORD_BITS), .DEPTH(DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.queue_cnt (q_cnt),
		.push      (push),
		.push_data (push_data)
	);

	// decouples the fixed-rate front from the stallable back
	qrs_fifo #(.WIDTH(EW), .DEPTH(DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_data  (pop_data),
		.count     (q_cnt)
	);

	// back: sqrt of |D|, numerator/denominator select, two dividers, clamp
	qrs_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (q_not_empty),
		.entry       (pop_data),
		.pop         (pop),
		.root        (root)
	);

`include "quadratic_root_solver_assert.svh"

	// the credit scheme must keep the queue from overflowing
	`QRS_ASSERT_NOW(a_no_overflow, q_cnt == CW'(DEPTH), !push, "queue overflow")
	// the back never pops an empty queue
	`QRS_ASSERT_NOW(a_no_underflow, pop, q_cnt != '0, "queue underflow")
	// no root values for the rootless kinds
	`QRS_ASSERT_NOW(a_rootless_zero,
		root.valid && (root.root_kind == qrs_pkg::KIND_CONST ||
		root.root_kind == qrs_pkg::KIND_IDENTITY),
		root.root_first == '0 && root.root_second == '0 && !root.saturated,
		"nonzero root for rootless kind")
	// imaginary part is a magnitude
	`QRS_ASSERT_NOW(a_imag_nonneg,
		root.valid && root.root_kind == qrs_pkg::KIND_COMPLEX,
		!root.root_second[WORD_BITS-1], "negative imaginary part")
	// a queued word enters the back right away when the output is free
	`QRS_ASSERT_NOW(a_pop_moves, q_not_empty && !root.valid, pop, "queue stuck")
endmodule
